FILE: design/dqd_pkg.sv
// ----------------------------------------------------------------------------
// dqd_pkg
// Shared widths, status codes and defaults for the deque with delete by value.
// ----------------------------------------------------------------------------
`default_nettype none

package dqd_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;

   localparam int unsigned ITEM_W     = 32;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned LENGTH_W   = 5;
   localparam int unsigned RSP_DATA_W = 40;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   typedef enum logic [KIND_W-1:0] {
      REQ_PREPEND = 2'd0,
      REQ_APPEND  = 2'd1,
      REQ_DEQUEUE = 2'd2,
      REQ_DELETE  = 2'd3
   } req_kind_type;

endpackage

`default_nettype wire

FILE: design/dqd_ram.sv
// ----------------------------------------------------------------------------
// dqd_ram
// Entry store: one write port, one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dqd_ram #(
   parameter int unsigned DEPTH = dqd_pkg::DEPTH_DEFAULT,
   parameter int unsigned WIDTH = dqd_pkg::ITEM_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/deque_with_delete_by_value.sv
// ----------------------------------------------------------------------------
// deque_with_delete_by_value
// Bounded deque of nonzero handles held in a circular buffer in one memory.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream: req_tuser carries the kind (prepend,
// append, dequeue head, delete first match), req_tdata the handle. Each
// request gives one result on the rsp_ stream: rsp_tuser carries the status,
// rsp_tdata the dequeued handle and the length held afterwards.
// Path from request transfer to result valid, with a free output register:
//   prepend, append, and any rejected or empty request: result written
//   directly into it; dequeue: one memory read of the head, then the result;
//   delete: one compare per entry up to the match, then the gap is closed;
//   the memory port does one compare or one gap-closing move per cycle.
// One request is in work at a time; the next is taken as soon as the current
// result has been handed to the output register, even while that result still
// waits for rsp_tready. When the receiver stalls and a second result is done,
// it is held and req_tready stays low until the output register frees.
// Reset empties the queue (pointers only) and drops any pending result; the
// memory is not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_delete_by_value #(
   parameter int unsigned DEPTH = dqd_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dqd_pkg::ITEM_W-1:0]      req_tdata,   // [31:0] item_value
   input  logic [dqd_pkg::KIND_W-1:0]      req_tuser,   // [1:0] req_type
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dqd_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [31:0] out_item, [36:32] length
   output logic [dqd_pkg::STATUS_W-1:0]    rsp_tuser    // [2:0] status
);

   import dqd_pkg::*;

   localparam int unsigned AW  = $clog2(DEPTH);
   localparam int unsigned CW  = $clog2(DEPTH + 1);
   localparam int unsigned PAD = RSP_DATA_W - ITEM_W - LENGTH_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEQ,
      S_CMP,
      S_SHIFT,
      S_WAIT
   } state_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ITEM_W-1:0]   item;
      logic [LENGTH_W-1:0] length;
   } result_type;

   function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
      logic [AW+1:0] sum;
      sum = {2'b00, base} + (AW+2)'(off);
      if (sum >= (AW+2)'(DEPTH)) begin
         sum = sum - (AW+2)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   state_type        state_ff, state_in;
   logic [AW-1:0]    head_ff, head_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [ITEM_W-1:0] key_ff, key_in;
   result_type       res_ff, res_in;
   result_type       rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic              accept;
   req_kind_type      kind;
   logic              slot_free;
   logic [AW-1:0]     head_dec;
   logic [CW-1:0]     idx_nx;
   logic [CW-1:0]     count_m1;
   logic              fin;
   logic [STATUS_W-1:0] fin_status;
   logic [ITEM_W-1:0] fin_item;
   logic [CW+LENGTH_W-1:0] len_ext;
   result_type        fin_res;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [ITEM_W-1:0] wr_data, rd_data;

   dqd_ram #(
      .DEPTH (DEPTH),
      .WIDTH (ITEM_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign kind       = req_kind_type'(req_tuser);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign head_dec   = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign idx_nx     = idx_ff + CW'(1);
   assign count_m1   = count_ff - CW'(1);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      wr_en        = 1'b0;
      wr_addr      = head_ff;
      wr_data      = req_tdata;
      fin          = 1'b0;
      fin_status   = ST_OK;
      fin_item     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (kind)
                  REQ_DEQUEUE: begin
                     if (count_ff == '0) begin
                        fin        = 1'b1;
                        fin_status = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        head_in  = wrap_add(head_ff, CW'(1));
                        count_in = count_m1;
                        state_in = S_DEQ;
                     end
                  end
                  REQ_DELETE: begin
                     if (req_tdata == '0) begin
                        fin        = 1'b1;
                        fin_status = ST_NULL;
                     end else if (count_ff == '0) begin
                        fin        = 1'b1;
                        fin_status = ST_NOTFOUND;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        key_in   = req_tdata;
                        idx_in   = '0;
                        state_in = S_CMP;
                     end
                  end
                  REQ_PREPEND, REQ_APPEND: begin
                     fin = 1'b1;
                     if (req_tdata == '0) begin
                        fin_status = ST_NULL;
                     end else if (count_ff == CW'(DEPTH)) begin
                        fin_status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                        if (kind == REQ_PREPEND) begin
                           wr_addr = head_dec;
                           head_in = head_dec;
                        end else begin
                           wr_addr = wrap_add(head_ff, count_ff);
                        end
                     end
                  end
               endcase
            end
         end
         S_DEQ: begin
            fin      = 1'b1;
            fin_item = rd_data;
         end
         S_CMP: begin
            if (rd_data == key_ff) begin
               if (idx_nx < count_ff) begin
                  rd_en    = 1'b1;
                  rd_addr  = wrap_add(head_ff, idx_nx);
                  state_in = S_SHIFT;
               end else begin
                  fin      = 1'b1;
                  count_in = count_m1;
               end
            end else if (idx_nx < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = wrap_add(head_ff, idx_nx);
               idx_in  = idx_nx;
            end else begin
               fin        = 1'b1;
               fin_status = ST_NOTFOUND;
            end
         end
         S_SHIFT: begin
            // move the entry after the gap one place toward the head
            wr_en   = 1'b1;
            wr_addr = wrap_add(head_ff, idx_ff);
            wr_data = rd_data;
            idx_in  = idx_nx;
            if (idx_nx < count_m1) begin
               rd_en   = 1'b1;
               rd_addr = wrap_add(head_ff, idx_nx + CW'(1));
            end else begin
               fin      = 1'b1;
               count_in = count_m1;
            end
         end
         S_WAIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      len_ext = {LENGTH_W'(0), count_in};
      fin_res = '{status: fin_status, item: fin_item, length: len_ext[LENGTH_W-1:0]};

      if (fin) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = fin_res;
            state_in     = S_IDLE;
         end else begin
            res_in   = fin_res;
            state_in = S_WAIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      key_ff <= key_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {PAD'(0), rsp_ff.length, rsp_ff.item};
   assign rsp_tuser  = rsp_ff.status;

endmodule

`default_nettype wire

FILE: design/dqd_checker.sv
// ----------------------------------------------------------------------------
// dqd_checker
// Port-level checks on the deque result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dqd_checker #(
   parameter int unsigned DEPTH = dqd_pkg::DEPTH_DEFAULT
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [dqd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [dqd_pkg::STATUS_W-1:0]    rsp_tuser
);

   import dqd_pkg::*;

   logic [ITEM_W-1:0]   out_item;
   logic [LENGTH_W-1:0] out_length;

   assign out_item   = rsp_tdata[ITEM_W-1:0];
   assign out_length = rsp_tdata[ITEM_W+LENGTH_W-1:ITEM_W];

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_item_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> out_item == '0)
      else $error("handle returned on a failed transfer");

   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_EMPTY |-> out_length == '0)
      else $error("empty status with nonzero length");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (DEPTH > 31) || (32'(out_length) <= DEPTH))
      else $error("length beyond depth");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL |-> (DEPTH > 31) || (32'(out_length) == DEPTH))
      else $error("full status below depth");

endmodule

bind deque_with_delete_by_value dqd_checker #(
   .DEPTH (DEPTH)
) u_dqd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
